// File: src/alin_pkg.sv
// Shared types, widths, channel codes and linearization tables for the ADC sample linearizer.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package alin_pkg;

  localparam int SAMPLE_W = 15;   // raw converter sample, signed
  localparam int CHAN_W   = 2;    // channel selector
  localparam int PROD_W   = 29;   // signed divider dividend
  localparam int DIVR_W   = 15;   // unsigned divisor
  localparam int QMAG_W   = 14;   // quotient magnitude bits
  localparam int QUOT_W   = 15;   // signed quotient
  localparam int MV_W     = 14;   // signed millivolts fed to the lookup
  localparam int CDEG_W   = 15;   // signed centidegrees
  localparam int NUM_W    = 24;   // signed interpolation numerator terms
  localparam int IDX_W    = 5;    // lookup index
  localparam int RECIP_SH = 29;   // fraction bits of the reciprocal gains
  localparam int RECIP_W  = 28;   // reciprocal gain width
  localparam int SCL_W    = SAMPLE_W + RECIP_W;   // magnitude * reciprocal

  localparam int FIFO_DEPTH_DEF = 2;

  localparam logic [CHAN_W-1:0] CH_IR  = 2'd0;
  localparam logic [CHAN_W-1:0] CH_AMB = 2'd1;
  localparam logic [CHAN_W-1:0] CH_BAT = 2'd2;
  localparam logic [CHAN_W-1:0] CH_SUP = 2'd3;

  // Reciprocal gains, rounded up: ceil(2^RECIP_SH * gain / divisor). With a sample
  // magnitude of at most 16384 the shifted product equals the truncated quotient.
  localparam logic [RECIP_W-1:0] RECIP_FULL =
    RECIP_W'(((64'd1 << RECIP_SH) * 64'd1000 + 64'd6826) / 64'd6827);   // IR and supply
  localparam logic [RECIP_W-1:0] RECIP_AMB =
    RECIP_W'(((64'd1 << RECIP_SH) * 64'd1000 + 64'd13652) / 64'd13653);
  localparam logic [RECIP_W-1:0] RECIP_BAT =
    RECIP_W'(((64'd1 << RECIP_SH) * 64'd11000 + 64'd27306) / 64'd27307);

  localparam logic signed [QUOT_W:0] IR_OFFSET_MV = 16'sd1024;

  localparam logic [IDX_W-1:0] IR_LAST  = 5'd6;
  localparam logic [IDX_W-1:0] AMB_LAST = 5'd25;

  typedef struct packed {
    logic [CHAN_W-1:0]   chan;
    logic                neg;
    logic [SAMPLE_W-1:0] mag;
    logic [RECIP_W-1:0]  recip;
  } q_entry_t;

  typedef struct packed {
    logic                     start;
    logic signed [PROD_W-1:0] dividend;
    logic [DIVR_W-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [QUOT_W-1:0] quot;
  } div_rsp_t;

  // Breakpoint voltages in mV. The ambient curve keeps 200 mV ahead of 198 mV.
  function automatic logic signed [MV_W-1:0] lut_mv(input logic amb,
                                                    input logic [IDX_W-1:0] idx);
    logic signed [MV_W-1:0] v;
    v = '0;
    if (amb) begin
      case (idx)
        5'd0:  v = 14'sd0;
        5'd1:  v = 14'sd18;
        5'd2:  v = 14'sd24;
        5'd3:  v = 14'sd32;
        5'd4:  v = 14'sd42;
        5'd5:  v = 14'sd53;
        5'd6:  v = 14'sd68;
        5'd7:  v = 14'sd86;
        5'd8:  v = 14'sd107;
        5'd9:  v = 14'sd133;
        5'd10: v = 14'sd200;
        5'd11: v = 14'sd198;
        5'd12: v = 14'sd239;
        5'd13: v = 14'sd285;
        5'd14: v = 14'sd340;
        5'd15: v = 14'sd393;
        5'd16: v = 14'sd454;
        5'd17: v = 14'sd521;
        5'd18: v = 14'sd590;
        5'd19: v = 14'sd662;
        5'd20: v = 14'sd736;
        5'd21: v = 14'sd811;
        5'd22: v = 14'sd885;
        5'd23: v = 14'sd958;
        5'd24: v = 14'sd1028;
        5'd25: v = 14'sd1096;
        default: v = 14'sd1096;
      endcase
    end else begin
      case (idx)
        5'd0:  v = -14'sd180;
        5'd1:  v = 14'sd0;
        5'd2:  v = 14'sd160;
        5'd3:  v = 14'sd240;
        5'd4:  v = 14'sd320;
        5'd5:  v = 14'sd480;
        5'd6:  v = 14'sd800;
        default: v = 14'sd800;
      endcase
    end
    return v;
  endfunction

  // Breakpoint temperatures in centidegrees.
  function automatic logic signed [CDEG_W-1:0] lut_cdeg(input logic amb,
                                                        input logic [IDX_W-1:0] idx);
    logic signed [CDEG_W-1:0] t;
    t = '0;
    if (amb) begin
      case (idx)
        5'd0:  t = -15'sd2000;
        5'd1:  t = -15'sd2000;
        5'd2:  t = -15'sd1500;
        5'd3:  t = -15'sd1000;
        5'd4:  t = -15'sd500;
        5'd5:  t = 15'sd0;
        5'd6:  t = 15'sd500;
        5'd7:  t = 15'sd1000;
        5'd8:  t = 15'sd1500;
        5'd9:  t = 15'sd2000;
        5'd10: t = 15'sd2500;
        5'd11: t = 15'sd3000;
        5'd12: t = 15'sd3500;
        5'd13: t = 15'sd4000;
        5'd14: t = 15'sd4500;
        5'd15: t = 15'sd5000;
        5'd16: t = 15'sd5550;
        5'd17: t = 15'sd6000;
        5'd18: t = 15'sd6500;
        5'd19: t = 15'sd7000;
        5'd20: t = 15'sd7500;
        5'd21: t = 15'sd8000;
        5'd22: t = 15'sd8500;
        5'd23: t = 15'sd9000;
        5'd24: t = 15'sd9500;
        5'd25: t = 15'sd10000;
        default: t = 15'sd10000;
      endcase
    end else begin
      case (idx)
        5'd0:  t = 15'sd0;
        5'd1:  t = 15'sd2500;
        5'd2:  t = 15'sd4500;
        5'd3:  t = 15'sd5500;
        5'd4:  t = 15'sd6250;
        5'd5:  t = 15'sd7500;
        5'd6:  t = 15'sd10000;
        default: t = 15'sd10000;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: src/alin_front.sv
// Front end of the linearizer: accepts a sample, splits it into sign and magnitude
// and picks the channel's reciprocal gain. Depends on alin_pkg.
`default_nettype none

module alin_front (
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [15:0]                          in_tdata,   // [14:0] raw_sample
  input  wire  [alin_pkg::CHAN_W-1:0]          in_tuser,   // [1:0] op
  input  wire                                  q_full,
  output logic                                 q_push,
  output alin_pkg::q_entry_t                   q_data
);
  import alin_pkg::*;

  logic signed [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0]        mag;

  assign sample = $signed(in_tdata[SAMPLE_W-1:0]);
  // The most negative sample maps to 16384, which still fits unsigned.
  assign mag    = sample[SAMPLE_W-1] ? (~$unsigned(sample) + SAMPLE_W'(1))
                                     : $unsigned(sample);

  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_data.chan = in_tuser;
    q_data.neg  = sample[SAMPLE_W-1];
    q_data.mag  = mag;
    case (in_tuser)
      CH_AMB:  q_data.recip = RECIP_AMB;
      CH_BAT:  q_data.recip = RECIP_BAT;
      default: q_data.recip = RECIP_FULL;
    endcase
  end

endmodule

`default_nettype wire

// File: src/alin_fifo.sv
// Short queue between the front end and the back end of the linearizer.
// Depends on alin_pkg for the entry type.
`default_nettype none

module alin_fifo #(
  parameter int DEPTH = alin_pkg::FIFO_DEPTH_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                push,
  input  alin_pkg::q_entry_t push_data,
  output logic               full,
  input  wire                pop,
  output alin_pkg::q_entry_t pop_data,
  output logic               empty
);
  import alin_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

// File: src/alin_div.sv
// Serial divider: signed dividend over unsigned divisor, one quotient bit
// per cycle, truncating toward zero. Depends on alin_pkg.
`default_nettype none

module alin_div (
  input  wire                clk,
  input  wire                rst_n,
  input  alin_pkg::div_req_t req,
  output alin_pkg::div_rsp_t rsp
);
  import alin_pkg::*;

  localparam int CNT_W = $clog2(QMAG_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [PROD_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0] dsh_r, dsh_nxt;
  logic [QMAG_W-1:0] q_r, q_nxt;
  logic [PROD_W-1:0] mag;
  logic              ge;
  logic [QUOT_W-1:0] q_ext;

  assign mag   = req.dividend[PROD_W-1] ? (~req.dividend + PROD_W'(1)) : req.dividend;
  assign ge    = (rem_r >= dsh_r);
  assign q_ext = {1'b0, q_r};

  assign rsp.done = done_r;
  assign rsp.quot = neg_r ? $signed(~q_ext + QUOT_W'(1)) : $signed(q_ext);

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[PROD_W-1];
      cnt_nxt  = '0;
      rem_nxt  = mag;
      dsh_nxt  = PROD_W'({req.divisor, {(QMAG_W-1){1'b0}}});
      q_nxt    = '0;
    end else if (busy_r) begin
      rem_nxt = ge ? (rem_r - dsh_r) : rem_r;
      dsh_nxt = dsh_r >> 1;
      q_nxt   = {q_r[QMAG_W-2:0], ge};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(QMAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    q_r   <= q_nxt;
  end

endmodule

`default_nettype wire

// File: src/alin_back.sv
// Back end of the linearizer: finishes the scaling, clamps, scans the breakpoint
// list, interpolates through the divider and holds the result. Depends on alin_pkg, alin_div.
`default_nettype none

module alin_back (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          q_empty,
  input  alin_pkg::q_entry_t           q_data,
  output logic                         q_pop,
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [15:0]                  out_tdata,  // [14:0] converted_value
  output logic [alin_pkg::CHAN_W-1:0]  out_tuser   // [1:0] channel_out
);
  import alin_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCALE = 3'd1;
  localparam logic [2:0] S_CLAMP = 3'd2;
  localparam logic [2:0] S_SRCH  = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_SUM   = 3'd5;
  localparam logic [2:0] S_DIV2  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]               state_r, state_nxt;
  logic [CHAN_W-1:0]        chan_r, chan_nxt;
  logic                     neg_r, neg_nxt;
  logic [SCL_W-1:0]         scl_r, scl_nxt;
  logic signed [MV_W-1:0]   mv_r, mv_nxt;
  logic [IDX_W-1:0]         hi_r, hi_nxt;
  logic signed [NUM_W-1:0]  pa_r, pa_nxt;
  logic signed [NUM_W-1:0]  pb_r, pb_nxt;
  logic [DIVR_W-1:0]        den_r, den_nxt;
  logic signed [QUOT_W-1:0] res_r, res_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]        out_chan_r, out_chan_nxt;
  logic signed [QUOT_W-1:0] out_val_r, out_val_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic                            amb;
  logic [IDX_W-1:0]                last_idx;
  logic [IDX_W-1:0]                lo_idx;
  logic signed [MV_W-1:0]          v_lo, v_hi, v_scan;
  logic signed [CDEG_W-1:0]        t_lo, t_hi;
  logic signed [MV_W-1:0]          d_lo, d_hi, d_span;
  logic signed [CDEG_W+MV_W-1:0]   pa_full, pb_full;
  logic signed [NUM_W-1:0]         num;
  logic [QMAG_W-1:0]               q_mag;
  logic [QUOT_W-1:0]               q_ext;
  logic signed [QUOT_W-1:0]        quot;
  logic signed [QUOT_W:0]          mv_wide;

  alin_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign amb      = (chan_r == CH_AMB);
  assign last_idx = amb ? AMB_LAST : IR_LAST;
  assign lo_idx   = hi_r - IDX_W'(1);
  assign v_lo     = lut_mv(amb, lo_idx);
  assign v_hi     = lut_mv(amb, hi_r);
  assign v_scan   = v_hi;
  assign t_lo     = lut_cdeg(amb, lo_idx);
  assign t_hi     = lut_cdeg(amb, hi_r);
  assign d_lo     = mv_r - v_lo;
  assign d_hi     = v_hi - mv_r;
  assign d_span   = v_hi - v_lo;
  assign pa_full  = t_lo * d_hi;
  assign pb_full  = t_hi * d_lo;
  assign num      = pa_r + pb_r;
  // Drop the reciprocal's fraction bits and restore the sign: truncation toward zero.
  assign q_mag    = scl_r[SCL_W-1:RECIP_SH];
  assign q_ext    = {1'b0, q_mag};
  assign quot     = neg_r ? $signed(~q_ext + QUOT_W'(1)) : $signed(q_ext);
  assign mv_wide  = $signed({quot[QUOT_W-1], quot})
                    - ((chan_r == CH_IR) ? IR_OFFSET_MV : '0);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_val_r};
  assign out_tuser  = out_chan_r;

  always_comb begin
    state_nxt     = state_r;
    chan_nxt      = chan_r;
    neg_nxt       = neg_r;
    scl_nxt       = scl_r;
    mv_nxt        = mv_r;
    hi_nxt        = hi_r;
    pa_nxt        = pa_r;
    pb_nxt        = pb_r;
    den_nxt       = den_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_chan_nxt  = out_chan_r;
    out_val_nxt   = out_val_r;
    q_pop         = 1'b0;
    div_req       = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          chan_nxt  = q_data.chan;
          neg_nxt   = q_data.neg;
          scl_nxt   = SCL_W'(q_data.mag) * SCL_W'(q_data.recip);
          state_nxt = S_SCALE;
        end
      end
      S_SCALE: begin
        if (chan_r == CH_BAT || chan_r == CH_SUP) begin
          res_nxt   = quot;
          state_nxt = S_OUT;
        end else begin
          mv_nxt    = mv_wide[MV_W-1:0];
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        if (mv_r <= lut_mv(amb, '0)) begin
          res_nxt   = lut_cdeg(amb, '0);
          state_nxt = S_OUT;
        end else if (mv_r >= lut_mv(amb, last_idx)) begin
          res_nxt   = lut_cdeg(amb, last_idx);
          state_nxt = S_OUT;
        end else begin
          hi_nxt    = IDX_W'(1);
          state_nxt = S_SRCH;
        end
      end
      S_SRCH: begin
        if (hi_r < last_idx && v_scan < mv_r) begin
          hi_nxt = hi_r + IDX_W'(1);
        end else begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        pa_nxt    = pa_full[NUM_W-1:0];
        pb_nxt    = pb_full[NUM_W-1:0];
        den_nxt   = DIVR_W'($unsigned(d_span));
        state_nxt = S_SUM;
      end
      S_SUM: begin
        div_req.start    = 1'b1;
        div_req.dividend = {{(PROD_W-NUM_W){num[NUM_W-1]}}, num};
        div_req.divisor  = den_r;
        state_nxt        = S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          res_nxt   = div_rsp.quot;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_chan_nxt  = chan_r;
          out_val_nxt   = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chan_r     <= chan_nxt;
    neg_r      <= neg_nxt;
    scl_r      <= scl_nxt;
    mv_r       <= mv_nxt;
    hi_r       <= hi_nxt;
    pa_r       <= pa_nxt;
    pb_r       <= pb_nxt;
    den_r      <= den_nxt;
    res_r      <= res_nxt;
    out_chan_r <= out_chan_nxt;
    out_val_r  <= out_val_nxt;
  end

endmodule

`default_nettype wire

// File: src/adc_sample_linearizer_core.sv
// ADC sample linearizer, top level: converts one raw converter sample per transaction
// into millivolts or centidegrees. Uses alin_pkg, alin_front, alin_fifo, alin_back.
//
// Usage:
//   Input stream: in_tdata[14:0] carries the signed 15-bit raw sample, in_tuser the
//   channel (0 IR temperature, 1 ambient temperature, 2 battery mV, 3 supply mV).
//   Output stream: exactly one transaction per input, in order; out_tdata[14:0] is the
//   signed converted value, out_tuser echoes the channel.
//   Timing: the front end splits off the sign, picks the channel's reciprocal gain and
//   pushes into a FIFO_DEPTH-entry queue, so in_tready stays high until the queue fills.
//   The back end takes one entry at a time: it multiplies by the gain as it pops the entry,
//   then scales to mV. Supply and battery go straight to the output register; a temperature
//   clamped at a curve end is settled by the clamp check; otherwise the breakpoint scan runs
//   at one entry per cycle and the 14-step serial divider interpolates. The next entry is
//   popped in the same cycle as out_tvalid rises, so a new entry is taken only once the
//   last result sits in the output register.
//   Reset: rst_n low (synchronous) empties the queue, idles the back end and drops
//   out_tvalid. No clearing pass is needed.
//   Stall: a finished result waits in the output register while out_tready is low;
//   the back end holds its next result, the queue keeps filling, then in_tready drops.
`default_nettype none

module adc_sample_linearizer_core #(
  parameter int FIFO_DEPTH = alin_pkg::FIFO_DEPTH_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  output logic                         in_tready,
  input  wire  [15:0]                  in_tdata,   // [14:0] raw_sample
  input  wire  [alin_pkg::CHAN_W-1:0]  in_tuser,   // [1:0] op
  output logic                         out_tvalid,
  input  wire                          out_tready,
  output logic [15:0]                  out_tdata,  // [14:0] converted_value
  output logic [alin_pkg::CHAN_W-1:0]  out_tuser   // [1:0] channel_out
);
  import alin_pkg::*;

  // Queue between the front end and the back end.
  q_entry_t push_data;
  q_entry_t pop_data;
  logic     q_push, q_full, q_pop, q_empty;

  // Accept, split off the sign and pick the reciprocal gain.
  alin_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (push_data)
  );

  alin_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .empty     (q_empty)
  );

  // Scale, clamp, scan, interpolate and hold the result.
  alin_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_data     (pop_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

// File: verif/testbench.sv
// Self-checking testbench for adc_sample_linearizer_core: a queue-fed stream driver,
// a scoreboarding monitor and a predictor of the sample-to-reading conversion.
// Depends on alin_pkg for channel codes and widths, and on the core RTL.
`default_nettype none

module testbench;
  import alin_pkg::*;

  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [SAMPLE_W-1:0] raw;
  } sample_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]          chan;
    logic signed [CDEG_W-1:0]   value;
  } reading_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  wire                 in_tready;
  logic [15:0]         in_tdata = '0;
  logic [CHAN_W-1:0]   in_tuser = '0;
  wire                 out_tvalid;
  logic                out_tready = 1'b0;
  wire  [15:0]         out_tdata;
  wire  [CHAN_W-1:0]   out_tuser;

  sample_item_t samples_to_send[$];
  reading_t     expected_readings[$];
  int           mismatch_count = 0;

  // Breakpoints of the two temperature curves; the ambient curve keeps 200 mV ahead of 198 mV.
  int ir_curve_mv[0:6]    = '{-180, 0, 160, 240, 320, 480, 800};
  int ir_curve_cdeg[0:6]  = '{0, 2500, 4500, 5500, 6250, 7500, 10000};
  int amb_curve_mv[0:25]  = '{0, 18, 24, 32, 42, 53, 68, 86, 107, 133, 200, 198, 239,
                              285, 340, 393, 454, 521, 590, 662, 736, 811, 885, 958,
                              1028, 1096};
  int amb_curve_cdeg[0:25] = '{-2000, -2000, -1500, -1000, -500, 0, 500, 1000, 1500,
                               2000, 2500, 3000, 3500, 4000, 4500, 5000, 5550, 6000,
                               6500, 7000, 7500, 8000, 8500, 9000, 9500, 10000};

  adc_sample_linearizer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Clamp to the end entries, otherwise interpolate between the scan's neighbors.
  function automatic int curve_lookup(bit amb, int mv);
    int n, i, hi, vl, vu, tl, tu;
    int pv[0:25];
    int pt[0:25];
    n = amb ? 26 : 7;
    for (i = 0; i < n; i++) begin
      pv[i] = amb ? amb_curve_mv[i] : ir_curve_mv[i];
      pt[i] = amb ? amb_curve_cdeg[i] : ir_curve_cdeg[i];
    end
    if (mv <= pv[0]) return pt[0];
    if (mv >= pv[n-1]) return pt[n-1];
    hi = 1;
    while (hi < n - 1 && pv[hi] < mv) hi++;
    vl = pv[hi-1];
    vu = pv[hi];
    tl = pt[hi-1];
    tu = pt[hi];
    if (vu == vl) return tu;
    return (tl * (vu - mv) + tu * (mv - vl)) / (vu - vl);
  endfunction

  // Scale to millivolts (integer division truncates toward zero), then linearize temperatures.
  function automatic logic signed [CDEG_W-1:0] linearize_sample(logic [CHAN_W-1:0] chan,
                                                                logic signed [SAMPLE_W-1:0] raw);
    int s, result;
    s = raw;
    case (chan)
      CH_IR:   result = curve_lookup(1'b0, s * 1000 / 6827 - 1024);
      CH_AMB:  result = curve_lookup(1'b1, s * 1000 / 13653);
      CH_BAT:  result = s * 11000 / 27307;
      default: result = s * 1000 / 6827;
    endcase
    return result[CDEG_W-1:0];
  endfunction

  // Smallest sample whose scaled millivolts reach the given curve voltage.
  function automatic int sample_for_mv(logic [CHAN_W-1:0] chan, int mv);
    int total;
    if (chan == CH_IR) begin
      total = mv + 1024;
      return (total * 6827 + 999) / 1000;
    end
    return (mv * 13653 + 999) / 1000;
  endfunction

  task automatic queue_sample(logic [CHAN_W-1:0] chan, int s);
    sample_item_t item;
    if (s > 16383) s = 16383;
    if (s < -16384) s = -16384;
    item.chan = chan;
    item.raw  = s[SAMPLE_W-1:0];
    samples_to_send.push_back(item);
  endtask

  // Driver: present one item per transaction, hold it while stalled, idle between items outside bursts.
  int in_gap = 0;
  bit in_burst = 1'b0;
  always @(posedge clk) begin
    sample_item_t item;
    reading_t     exp_r;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!(in_tvalid && !in_tready)) begin
      if (in_tvalid) begin
        // Transaction accepted at this edge: predict its reading.
        exp_r.chan  = in_tuser;
        exp_r.value = linearize_sample(in_tuser, in_tdata[SAMPLE_W-1:0]);
        expected_readings.push_back(exp_r);
      end
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (samples_to_send.size() != 0) begin
        item = samples_to_send.pop_front();
        in_tdata  <= {1'b0, item.raw};
        in_tuser  <= item.chan;
        in_tvalid <= 1'b1;
        if ($urandom_range(0, 49) == 0) in_burst = ~in_burst;
        in_gap <= in_burst ? 0 : $urandom_range(0, 8);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Monitor: compare each output transaction with the oldest prediction, then stall a while outside bursts.
  int out_stall = 0;
  bit out_burst = 1'b0;
  always @(posedge clk) begin
    reading_t exp_r;
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_stall  <= 0;
    end else if (out_tvalid && out_tready) begin
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected output, expected none, actual chan %0d value %0d",
                 $time, out_tuser, $signed(out_tdata[SAMPLE_W-1:0]));
      end else begin
        exp_r = expected_readings.pop_front();
        if (out_tuser !== exp_r.chan) begin
          mismatch_count++;
          $display("%0t: channel mismatch, expected %0d, actual %0d",
                   $time, exp_r.chan, out_tuser);
        end
        if (out_tdata !== {1'b0, exp_r.value}) begin
          mismatch_count++;
          $display("%0t: value mismatch on chan %0d, expected %0d (%h), actual %0d (%h)",
                   $time, exp_r.chan, exp_r.value, {1'b0, exp_r.value},
                   $signed(out_tdata[SAMPLE_W-1:0]), out_tdata);
        end
      end
      if ($urandom_range(0, 49) == 0) out_burst = ~out_burst;
      if (out_burst) begin
        out_tready <= 1'b1;
      end else begin
        out_stall  <= $urandom_range(0, 8);
        out_tready <= 1'b0;
      end
    end else if (!out_tready) begin
      if (out_stall > 0) out_stall <= out_stall - 1;
      else out_tready <= 1'b1;
    end
  end

  // Stimulus, reset and end of run.
  initial begin
    int ch, pick, s, i;
    logic [CHAN_W-1:0] op;

    // Directed: sample extremes on every channel, both ends of the nominal range.
    for (ch = 0; ch < 4; ch++) begin
      op = ch[CHAN_W-1:0];
      queue_sample(op, -16384);
      queue_sample(op, 16383);
      queue_sample(op, -2048);
      queue_sample(op, 0);
      queue_sample(op, -1);
    end
    // Ambient entries stored out of order, and the low IR clamp point.
    queue_sample(CH_AMB, sample_for_mv(CH_AMB, 198));
    queue_sample(CH_AMB, sample_for_mv(CH_AMB, 199));
    queue_sample(CH_AMB, sample_for_mv(CH_AMB, 200));
    queue_sample(CH_AMB, sample_for_mv(CH_AMB, 201));
    queue_sample(CH_IR, sample_for_mv(CH_IR, -180));

    // Random: mostly nominal samples, many near curve breakpoints, some full-range.
    for (i = 0; i < 1800; i++) begin
      op   = CHAN_W'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        s = int'($urandom_range(0, 32767)) - 16384;
      end else if (pick < 50 && (op == CH_IR || op == CH_AMB)) begin
        if (op == CH_AMB) s = sample_for_mv(op, amb_curve_mv[$urandom_range(0, 25)]);
        else s = sample_for_mv(op, ir_curve_mv[$urandom_range(0, 6)]);
        s = s + int'($urandom_range(0, 40)) - 20;
      end else begin
        s = int'($urandom_range(0, 18431)) - 2048;
      end
      queue_sample(op, s);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: all items sent and accepted, every prediction matched.
    while (samples_to_send.size() != 0 || in_tvalid || expected_readings.size() != 0)
      @(posedge clk);
    // Allow for the slowest back-end pass before judging stray outputs.
    repeat (80) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[adc_sample_linearizer_core] OK");
    end else begin
      $display("[adc_sample_linearizer_core] ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #(12 * 900000);
    $display("[adc_sample_linearizer_core] ERROR");
    $finish;
  end

endmodule

`default_nettype wire

// File: adc_sample_linearizer_core.f
src/alin_pkg.sv
src/alin_front.sv
src/alin_fifo.sv
src/alin_div.sv
src/alin_back.sv
src/adc_sample_linearizer_core.sv
verif/testbench.sv
